// ===== src/slbm_pkg.sv =====
// ============================================================================
// slbm_pkg
// Shared types, constants and helpers of the serial loaded bank mapper.
// ============================================================================
package slbm_pkg;

    // Bank count limits
    localparam int MAX_PROGRAM_BANKS   = 32;
    localparam int MAX_CHARACTER_BANKS = 32;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int COUNT_W  = 6;
    localparam int BANK_W   = 8;
    localparam int PRG_W    = 19;
    localparam int CHR_W    = 17;
    localparam int REGION_W = 3;
    localparam int QUEUE_DEPTH = 2;

    // Opcodes of an input item
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_LOAD  = 2'd2;

    // Region codes of a result item
    localparam logic [REGION_W-1:0] REGION_CHR       = 3'd0;
    localparam logic [REGION_W-1:0] REGION_PRG       = 3'd1;
    localparam logic [REGION_W-1:0] REGION_NOSRAM    = 3'd2;
    localparam logic [REGION_W-1:0] REGION_UNHANDLED = 3'd3;
    localparam logic [REGION_W-1:0] REGION_LOAD      = 3'd4;

    // Configuration register indexes
    localparam logic CFG_PRG_COUNT = 1'b0;
    localparam logic CFG_CHR_COUNT = 1'b1;

    // Reset values and masks
    localparam logic [COUNT_W-1:0] PRG_COUNT_RST = 6'd8;
    localparam logic [COUNT_W-1:0] CHR_COUNT_RST = 6'd2;
    localparam logic [4:0]         SHIFT_INIT    = 5'h10;
    localparam logic [4:0]         CTRL_MODE3    = 5'h0C;
    localparam logic [BANK_W-1:0]  BANK_LAST     = 8'hFF;
    localparam logic [PRG_W-1:0]   PRG_OFF1_RST  = PRG_W'((int'(PRG_COUNT_RST) - 1) << 14);

    // Address boundaries
    localparam logic [ADDR_W-1:0] ADDR_NOSRAM_LO = 16'h6000;
    localparam logic [ADDR_W-1:0] ADDR_CHR_HI    = 16'h2000;
    localparam logic [ADDR_W-1:0] ADDR_PRG_LO    = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_CHR0_REG  = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_CHR1_REG  = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_PRG_REG   = 16'hE000;

    // Item class decided by the front end
    typedef enum logic [2:0] {
        KIND_CHR,
        KIND_PRG,
        KIND_NOSRAM,
        KIND_UNHANDLED,
        KIND_LOAD
    } slbm_kind_t;

    typedef struct packed {
        slbm_kind_t         kind;
        logic               wr;
        logic [ADDR_W-1:0]  address;
        logic [DATA_W-1:0]  data;
    } slbm_item_t;

    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [PRG_W-1:0]    physical_offset;
        logic                is_write;
        logic [DATA_W-1:0]   write_data;
        logic [1:0]          mirroring;
    } slbm_result_t;

    typedef struct packed {
        logic               full;
        logic               empty;
    } slbm_q_status_t;

    typedef struct packed {
        logic               start;
        logic [BANK_W-1:0]  bank;
        logic [COUNT_W-1:0] count;
    } slbm_mod_req_t;

    typedef struct packed {
        logic               done;
        logic [COUNT_W-1:0] remainder;
    } slbm_mod_rsp_t;

    // Force a bank count into 1..maxc
    function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] c, int maxc);
        if (c == '0)
            return COUNT_W'(1);
        if (int'(c) > maxc)
            return COUNT_W'(maxc);
        return c;
    endfunction

endpackage

// ===== src/slbm_front.sv =====
// ============================================================================
// slbm_front
// Accepts bus items and classifies them by opcode and address.
// ============================================================================
module slbm_front
    import slbm_pkg::*;
(
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // address[15:0], data[23:16]
    input  logic [1:0]            s_tuser,   // opcode[1:0]
    input  slbm_q_status_t        q_status,
    output logic                  push,
    output slbm_item_t            item
);

    logic [ADDR_W-1:0] addr;

    assign addr     = s_tdata[ADDR_W-1:0];
    assign s_tready = !q_status.full;
    assign push     = s_tvalid && !q_status.full;

    // Decode the item class
    always_comb
    begin
        item.address = addr;
        item.data    = s_tdata[ADDR_W +: DATA_W];
        item.wr      = (s_tuser == OP_WRITE);
        item.kind    = KIND_UNHANDLED;
        unique case (s_tuser) inside
            OP_LOAD:
            begin
                if (addr >= ADDR_PRG_LO)
                    item.kind = KIND_LOAD;
            end
            OP_READ, OP_WRITE:
            begin
                if (addr < ADDR_CHR_HI)
                    item.kind = KIND_CHR;
                else if (addr >= ADDR_PRG_LO)
                    item.kind = KIND_PRG;
                else if (addr >= ADDR_NOSRAM_LO)
                    item.kind = KIND_NOSRAM;
            end
            default:
                item.kind = KIND_UNHANDLED;
        endcase
    end

endmodule

// ===== src/slbm_queue.sv =====
// ============================================================================
// slbm_queue
// Short queue of classified items between the front and back ends.
// ============================================================================
module slbm_queue
    import slbm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  slbm_item_t      item_in,
    input  logic            pop,
    output slbm_item_t      item_out,
    output slbm_q_status_t  status
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    slbm_item_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;

    assign status.full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign status.empty = (fill_reg == '0);
    assign item_out     = slot_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            fill_next = fill_reg + 1'b1;
        else if (pop && !push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Store the item
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= item_in;
    end

endmodule

// ===== src/slbm_modulo.sv =====
// ============================================================================
// slbm_modulo
// Iterative signed bank modulo: two remainder bits a cycle, wrapped result.
// ============================================================================
module slbm_modulo
    import slbm_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  slbm_mod_req_t  req,
    output slbm_mod_rsp_t  rsp
);

    localparam int STEPS = BANK_W / 2;

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [$clog2(STEPS)-1:0]    step_reg, step_next;
    logic [BANK_W-1:0]           mag_reg, mag_next;
    logic [COUNT_W-1:0]          rem_reg, rem_next;
    logic [COUNT_W-1:0]          res_reg, res_next;
    logic [COUNT_W-1:0]          cnt_reg, cnt_next;
    logic                        neg_reg, neg_next;
    logic [COUNT_W:0]            try1, try2;
    logic [COUNT_W-1:0]          rem1;

    assign rsp.done      = done_reg;
    assign rsp.remainder = res_reg;

    // Two restoring steps on the magnitude
    always_comb
    begin
        try1 = {rem_reg, mag_reg[BANK_W-1]};
        if (try1 >= {1'b0, cnt_reg})
            try1 = try1 - {1'b0, cnt_reg};
        rem1 = try1[COUNT_W-1:0];
        try2 = {rem1, mag_reg[BANK_W-2]};
        if (try2 >= {1'b0, cnt_reg})
            try2 = try2 - {1'b0, cnt_reg};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        res_next  = res_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            mag_next  = req.bank[BANK_W-1] ? BANK_W'(-req.bank) : req.bank;
            rem_next  = '0;
            cnt_next  = req.count;
            neg_next  = req.bank[BANK_W-1];
        end
        else if (busy_reg)
        begin
            mag_next  = {mag_reg[BANK_W-3:0], 2'b00};
            rem_next  = try2[COUNT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == ($clog2(STEPS))'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                // wrap a negative remainder into range
                res_next = (neg_reg && try2[COUNT_W-1:0] != '0)
                         ? cnt_reg - try2[COUNT_W-1:0] : try2[COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        res_reg <= res_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
    end

endmodule

// ===== src/slbm_back.sv =====
// ============================================================================
// slbm_back
// Holds mapper state, executes items, recomputes bank offsets, drives results.
// ============================================================================
module slbm_back
    import slbm_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  slbm_item_t      item,
    input  slbm_q_status_t  q_status,
    output logic            pop,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_index,
    input  logic [5:0]      cfg_data,
    output logic            out_valid,
    input  logic            out_ready,
    output slbm_result_t    result
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_CALC = 2'b10
    } back_state_t;

    back_state_t         state_reg, state_next;
    logic [1:0]          job_reg, job_next;
    logic                issued_reg, issued_next;
    logic                fresh_reg, fresh_next;
    logic [COUNT_W-1:0]  prg_count_reg, prg_count_next;
    logic [COUNT_W-1:0]  chr_count_reg, chr_count_next;
    logic [4:0]          shift_reg, shift_next;
    logic [4:0]          ctrl_reg, ctrl_next;
    logic [3:0]          prg_bank_reg, prg_bank_next;
    logic [4:0]          chr_low_reg, chr_low_next;
    logic [4:0]          chr_high_reg, chr_high_next;
    logic [PRG_W-1:0]    prg_off_reg [2];
    logic [PRG_W-1:0]    prg_off_next [2];
    logic [CHR_W-1:0]    chr_off_reg [2];
    logic [CHR_W-1:0]    chr_off_next [2];
    logic                out_valid_reg, out_valid_next;
    slbm_result_t        result_reg, result_next;

    slbm_mod_req_t       mod_req;
    slbm_mod_rsp_t       mod_rsp;
    logic [BANK_W-1:0]   prg_b0, prg_b1, chr_b0, chr_b1;
    logic [1:0]          prg_layout;
    logic [4:0]          shifted;
    logic                recalc;
    logic [PRG_W-1:0]    prg_scaled;
    logic [CHR_W-1:0]    chr_scaled;

    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign cfg_ready = (state_reg == S_IDLE);
    assign pop       = (state_reg == S_IDLE) && !cfg_valid && !q_status.empty
                    && (!out_valid_reg || out_ready);

    slbm_modulo u_modulo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // Pick the bank numbers for the four offsets
    always_comb
    begin
        prg_layout = ctrl_reg[3:2];
        prg_b0     = '0;
        prg_b1     = BANK_LAST;
        chr_b0     = '0;
        chr_b1     = '0;
        if (!fresh_reg)
        begin
            unique case (prg_layout) inside
                2'd0, 2'd1:
                begin
                    prg_b0 = {4'b0, prg_bank_reg[3:1], 1'b0};
                    prg_b1 = {4'b0, prg_bank_reg[3:1], 1'b1};
                end
                2'd2:
                begin
                    prg_b0 = '0;
                    prg_b1 = {4'b0, prg_bank_reg};
                end
                default:
                begin
                    prg_b0 = {4'b0, prg_bank_reg};
                    prg_b1 = BANK_LAST;
                end
            endcase
            if (!ctrl_reg[4])
            begin
                chr_b0 = {3'b0, chr_low_reg[4:1], 1'b0};
                chr_b1 = {3'b0, chr_low_reg[4:1], 1'b1};
            end
            else
            begin
                chr_b0 = {3'b0, chr_low_reg};
                chr_b1 = {3'b0, chr_high_reg};
            end
        end
    end

    // Feed the modulo unit with the current job
    always_comb
    begin
        mod_req.start = (state_reg == S_CALC) && !issued_reg;
        mod_req.count = job_reg[1] ? clamp_count(chr_count_reg, MAX_CHARACTER_BANKS)
                                   : clamp_count(prg_count_reg, MAX_PROGRAM_BANKS);
        case (job_reg)
            2'd0:    mod_req.bank = prg_b0;
            2'd1:    mod_req.bank = prg_b1;
            2'd2:    mod_req.bank = chr_b0;
            default: mod_req.bank = chr_b1;
        endcase
    end

    assign prg_scaled = PRG_W'({mod_rsp.remainder, 14'b0});
    assign chr_scaled = CHR_W'({mod_rsp.remainder, 12'b0});
    assign shifted    = {item.data[0], shift_reg[4:1]};

    // Execute items, take register writes, step through the offsets
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        issued_next     = issued_reg;
        fresh_next      = fresh_reg;
        prg_count_next  = prg_count_reg;
        chr_count_next  = chr_count_reg;
        shift_next      = shift_reg;
        ctrl_next       = ctrl_reg;
        prg_bank_next   = prg_bank_reg;
        chr_low_next    = chr_low_reg;
        chr_high_next   = chr_high_reg;
        prg_off_next    = prg_off_reg;
        chr_off_next    = chr_off_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        result_next     = result_reg;
        recalc          = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_index == CFG_PRG_COUNT)
                        prg_count_next = cfg_data;
                    else
                        chr_count_next = cfg_data;
                    recalc = 1'b1;
                end
                else if (pop)
                begin
                    out_valid_next              = 1'b1;
                    result_next.region          = REGION_UNHANDLED;
                    result_next.physical_offset = '0;
                    result_next.is_write        = 1'b0;
                    result_next.write_data      = '0;
                    case (item.kind)
                        KIND_CHR:
                        begin
                            result_next.region          = REGION_CHR;
                            result_next.physical_offset =
                                PRG_W'(chr_off_reg[item.address[12]])
                                + PRG_W'(item.address[11:0]);
                            result_next.is_write        = item.wr;
                            result_next.write_data      = item.wr ? item.data : '0;
                        end
                        KIND_PRG:
                        begin
                            result_next.region          = REGION_PRG;
                            result_next.physical_offset =
                                prg_off_reg[item.address[14]]
                                + PRG_W'(item.address[13:0]);
                            result_next.is_write        = item.wr;
                            result_next.write_data      = item.wr ? item.data : '0;
                        end
                        KIND_NOSRAM:
                            result_next.region = REGION_NOSRAM;
                        KIND_LOAD:
                        begin
                            result_next.region = REGION_LOAD;
                            if (item.data[7])
                            begin
                                shift_next = SHIFT_INIT;
                                ctrl_next  = ctrl_reg | CTRL_MODE3;
                                recalc     = 1'b1;
                            end
                            else if (shift_reg[0])
                            begin
                                // fifth bit: commit to the addressed register
                                if (item.address < ADDR_CHR0_REG)
                                    ctrl_next = shifted;
                                else if (item.address < ADDR_CHR1_REG)
                                    chr_low_next = shifted;
                                else if (item.address < ADDR_PRG_REG)
                                    chr_high_next = shifted;
                                else
                                    prg_bank_next = shifted[3:0];
                                shift_next = SHIFT_INIT;
                                recalc     = 1'b1;
                            end
                            else
                                shift_next = shifted;
                            if (recalc)
                                fresh_next = 1'b0;
                        end
                        default:
                            result_next.region = REGION_UNHANDLED;
                    endcase
                    result_next.mirroring = ctrl_next[1:0];
                end
                if (recalc)
                begin
                    state_next  = S_CALC;
                    job_next    = '0;
                    issued_next = 1'b0;
                end
            end
            S_CALC:
            begin
                if (!issued_reg)
                    issued_next = 1'b1;
                else if (mod_rsp.done)
                begin
                    case (job_reg)
                        2'd0:    prg_off_next[0] = prg_scaled;
                        2'd1:    prg_off_next[1] = prg_scaled;
                        2'd2:    chr_off_next[0] = chr_scaled;
                        default: chr_off_next[1] = chr_scaled;
                    endcase
                    issued_next = 1'b0;
                    job_next    = job_reg + 1'b1;
                    if (job_reg == 2'd3)
                        state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            job_reg        <= '0;
            issued_reg     <= 1'b0;
            fresh_reg      <= 1'b1;
            prg_count_reg  <= PRG_COUNT_RST;
            chr_count_reg  <= CHR_COUNT_RST;
            shift_reg      <= SHIFT_INIT;
            ctrl_reg       <= '0;
            prg_bank_reg   <= '0;
            chr_low_reg    <= '0;
            chr_high_reg   <= '0;
            prg_off_reg[0] <= '0;
            prg_off_reg[1] <= PRG_OFF1_RST;
            chr_off_reg[0] <= '0;
            chr_off_reg[1] <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            job_reg        <= job_next;
            issued_reg     <= issued_next;
            fresh_reg      <= fresh_next;
            prg_count_reg  <= prg_count_next;
            chr_count_reg  <= chr_count_next;
            shift_reg      <= shift_next;
            ctrl_reg       <= ctrl_next;
            prg_bank_reg   <= prg_bank_next;
            chr_low_reg    <= chr_low_next;
            chr_high_reg   <= chr_high_next;
            prg_off_reg    <= prg_off_next;
            chr_off_reg    <= chr_off_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    // Recompute never overlaps item execution
    a_no_pop_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CALC) |-> !pop)
        else $error("item popped during offset recompute");

    // The shifter marker bit is never lost
    a_shift_marker: assert property (@(posedge clk) disable iff (!rst_n)
        shift_reg != '0)
        else $error("load shifter lost its marker");

    // The modulo unit answers only while recomputing
    a_mod_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (state_reg == S_CALC) && issued_reg)
        else $error("stray modulo result");

    // A configuration write starts a recompute
    a_cfg_recalc: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> (state_reg == S_CALC) && (job_reg == 2'd0))
        else $error("configuration write did not start a recompute");

    // Remainder stays below the bank count it was taken against
    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_rsp.done |-> (mod_rsp.remainder < mod_req.count))
        else $error("modulo result out of range");

endmodule

// ===== src/serial_loaded_bank_mapper.sv =====
// ============================================================================
// serial_loaded_bank_mapper
// Cartridge bank mapper with five-bit serial register loading.
// ============================================================================
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+----------------------------------
//  s_      | in        | s_tvalid/s_tready | tdata address,data; tuser opcode
//  m_      | out       | m_tvalid/m_tready | tdata offset,wr,wdata,mirror;
//          |           |                   | tuser region
//  cfg_    | in        | cfg_valid/ready   | cfg_index, cfg_data (6 bit)
//
//  A read, write or non-committing load item is executed by the back end as it
//  is popped from the queue; its result is registered as the item is popped.
//  A committing load, a shifter clear and each configuration write then
//  recompute four bank offsets through one iterative modulo unit, one offset
//  after another, during which the back end takes no item; the front
//  keeps filling a two-entry queue. Reset is asynchronous, active low.
// ============================================================================
module serial_loaded_bank_mapper
    import slbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // address[15:0], data[23:16]
    input  logic [1:0]  s_tuser,    // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // physical_offset[18:0], is_write[19],
                                    // write_data[27:20], mirroring[29:28]
    output logic [2:0]  m_tuser,    // region[2:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [5:0]  cfg_data
);

    slbm_item_t      front_item;
    slbm_item_t      queue_item;
    slbm_q_status_t  q_status;
    slbm_result_t    result;
    logic            push;
    logic            pop;

    slbm_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .item     (front_item)
    );

    slbm_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (front_item),
        .pop      (pop),
        .item_out (queue_item),
        .status   (q_status)
    );

    slbm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (queue_item),
        .q_status  (q_status),
        .pop       (pop),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .result    (result)
    );

    // Pack the result item
    assign m_tuser = result.region;
    assign m_tdata = {2'b00, result.mirroring, result.write_data,
                      result.is_write, result.physical_offset};

endmodule

// ===== sim/testbench.sv =====
// ============================================================================
// testbench
// Self-checking bench for the serial loaded bank mapper. A shadow copy of the
// mapper state predicts the result of every accepted item: region, physical
// offset, write flag, write data and mirroring. The run covers power-up
// offsets, the address map, serial register loads, and a sweep of bank
// counts under random traffic, with random idling on both streams.
// ============================================================================
module testbench
    import slbm_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam int         SETTLE_CYCLES = 48;
    localparam int         CYCLE_LIMIT   = 600000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // address[15:0], data[23:16]
    logic [1:0]  s_tuser;    // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // physical_offset[18:0], is_write[19],
                             // write_data[27:20], mirroring[29:28]
    logic [2:0]  m_tuser;    // region[2:0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [5:0]  cfg_data;

    // Shadow copy of the mapper state
    logic [COUNT_W-1:0] shadow_prg_count = PRG_COUNT_RST;
    logic [COUNT_W-1:0] shadow_chr_count = CHR_COUNT_RST;
    logic [4:0]         shadow_shifter   = SHIFT_INIT;
    logic [4:0]         shadow_ctrl      = '0;
    logic [3:0]         shadow_prg_bank  = '0;
    logic [BANK_W-1:0]  shadow_chr_low   = '0;
    logic [BANK_W-1:0]  shadow_chr_high  = '0;
    logic [PRG_W-1:0]   shadow_prg_offset [2];
    logic [CHR_W-1:0]   shadow_chr_offset [2];
    logic               shadow_fresh     = 1'b1;

    slbm_result_t pending_translations [$];
    int           src_gap_max   = 5;
    int           snk_stall_max = 5;
    int           mapped_items  = 0;
    int           error_count   = 0;
    int           cycle_count   = 0;

    serial_loaded_bank_mapper u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Abandon a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Bank number as signed 8 bits, truncating modulo, negative remainder wrapped
    function automatic int wrap_bank(logic [BANK_W-1:0] bank, logic [COUNT_W-1:0] count,
                                     int maxc);
        int n;
        int r;
        n = (count == 0) ? 1 : ((int'(count) > maxc) ? maxc : int'(count));
        r = int'($signed(bank)) % n;
        if (r < 0)
            r += n;
        return r;
    endfunction

    function automatic logic [PRG_W-1:0] prg_bank_start(logic [BANK_W-1:0] bank);
        return PRG_W'(wrap_bank(bank, shadow_prg_count, MAX_PROGRAM_BANKS) << 14);
    endfunction

    function automatic logic [CHR_W-1:0] chr_bank_start(logic [BANK_W-1:0] bank);
        return CHR_W'(wrap_bank(bank, shadow_chr_count, MAX_CHARACTER_BANKS) << 12);
    endfunction

    function automatic void load_power_up_offsets();
        shadow_prg_offset[0] = '0;
        shadow_prg_offset[1] = prg_bank_start(BANK_LAST);
        shadow_chr_offset[0] = '0;
        shadow_chr_offset[1] = '0;
    endfunction

    function automatic void recompute_offsets();
        logic [BANK_W-1:0] prg;
        prg = BANK_W'(shadow_prg_bank);
        case (shadow_ctrl[3:2]) inside
            2'd0, 2'd1:
            begin
                shadow_prg_offset[0] = prg_bank_start(prg & 8'hFE);
                shadow_prg_offset[1] = prg_bank_start(prg | 8'h01);
            end
            2'd2:
            begin
                shadow_prg_offset[0] = '0;
                shadow_prg_offset[1] = prg_bank_start(prg);
            end
            default:
            begin
                shadow_prg_offset[0] = prg_bank_start(prg);
                shadow_prg_offset[1] = prg_bank_start(BANK_LAST);
            end
        endcase
        if (!shadow_ctrl[4])
        begin
            shadow_chr_offset[0] = chr_bank_start(shadow_chr_low & 8'hFE);
            shadow_chr_offset[1] = chr_bank_start(shadow_chr_low | 8'h01);
        end
        else
        begin
            shadow_chr_offset[0] = chr_bank_start(shadow_chr_low);
            shadow_chr_offset[1] = chr_bank_start(shadow_chr_high);
        end
    endfunction

    // Advance the shadow state by one item and return its translation
    function automatic slbm_result_t translate_item(logic [1:0] op, logic [15:0] addr,
                                                    logic [7:0] data);
        slbm_result_t r;
        logic         done;
        r        = '0;
        r.region = REGION_UNHANDLED;
        if (op == OP_LOAD)
        begin
            if (addr >= ADDR_PRG_LO)
            begin
                r.region = REGION_LOAD;
                if (data[7])
                begin
                    shadow_shifter = SHIFT_INIT;
                    shadow_ctrl    = shadow_ctrl | CTRL_MODE3;
                    shadow_fresh   = 1'b0;
                    recompute_offsets();
                end
                else
                begin
                    done           = shadow_shifter[0];
                    shadow_shifter = {data[0], shadow_shifter[4:1]};
                    if (done)
                    begin
                        if (addr < ADDR_CHR0_REG)
                            shadow_ctrl = shadow_shifter;
                        else if (addr < ADDR_CHR1_REG)
                            shadow_chr_low = BANK_W'(shadow_shifter);
                        else if (addr < ADDR_PRG_REG)
                            shadow_chr_high = BANK_W'(shadow_shifter);
                        else
                            shadow_prg_bank = shadow_shifter[3:0];
                        shadow_shifter = SHIFT_INIT;
                        shadow_fresh   = 1'b0;
                        recompute_offsets();
                    end
                end
            end
        end
        else if (op != OP_UNUSED)
        begin
            if (addr < ADDR_CHR_HI)
            begin
                r.region          = REGION_CHR;
                r.physical_offset = PRG_W'(shadow_chr_offset[addr[12]]) + PRG_W'(addr[11:0]);
            end
            else if (addr >= ADDR_NOSRAM_LO && addr < ADDR_PRG_LO)
                r.region = REGION_NOSRAM;
            else if (addr >= ADDR_PRG_LO)
            begin
                r.region          = REGION_PRG;
                r.physical_offset = shadow_prg_offset[addr[14]] + PRG_W'(addr[13:0]);
            end
            if (op == OP_WRITE && (r.region == REGION_CHR || r.region == REGION_PRG))
            begin
                r.is_write   = 1'b1;
                r.write_data = data;
            end
        end
        r.mirroring = shadow_ctrl[1:0];
        return r;
    endfunction

    // Offer one item after a random gap and record its translation on acceptance
    task automatic send_item(logic [1:0] op, logic [15:0] addr, logic [7:0] data);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, addr};
        s_tuser  <= op;
        do @(posedge clk); while (!s_tready);
        pending_translations.push_back(translate_item(op, addr, data));
        if (!(op == OP_UNUSED || (op == OP_LOAD && addr < ADDR_PRG_LO)))
            mapped_items++;
    endtask

    // Hold the input until every translation has come back, then let the block settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (pending_translations.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic idx, logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_PRG_COUNT)
            shadow_prg_count = value;
        else
            shadow_chr_count = value;
        if (shadow_fresh)
            load_power_up_offsets();
        else
            recompute_offsets();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_bank_counts(logic [COUNT_W-1:0] prg, logic [COUNT_W-1:0] chr);
        wait_idle();
        write_register(CFG_PRG_COUNT, prg);
        write_register(CFG_CHR_COUNT, chr);
    endtask

    // Shift a five-bit value in, lowest bit first; the address picks the register
    task automatic load_register(logic [15:0] addr, logic [4:0] value);
        for (int i = 0; i < 5; i++)
            send_item(OP_LOAD, addr, {1'b0, 6'($urandom), value[i]});
    endtask

    task automatic random_access();
        logic [15:0] addr;
        case ($urandom_range(0, 5)) inside
            0, 1:    addr = 16'($urandom_range(0, 16'h1FFF));
            2, 3:    addr = 16'($urandom_range(16'h8000, 16'hFFFF));
            4:       addr = 16'($urandom_range(16'h6000, 16'h7FFF));
            default: addr = 16'($urandom);
        endcase
        send_item(($urandom_range(0, 1) != 0) ? OP_WRITE : OP_READ, addr, 8'($urandom));
    endtask

    task automatic random_traffic(int target);
        int          stop_at;
        int          n;
        logic [15:0] addr;
        stop_at = mapped_items + target;
        while (mapped_items < stop_at)
        begin
            n    = $urandom_range(0, 19);
            addr = 16'($urandom_range(16'h8000, 16'hFFFF));
            if (n < 11)
            begin
                // Full register update followed by a few accesses
                load_register(addr, 5'($urandom));
                repeat ($urandom_range(1, 4)) random_access();
            end
            else if (n < 16)
                random_access();
            else if (n < 18)
            begin
                // Partial load cut short by a shifter reset
                repeat ($urandom_range(1, 4))
                    send_item(OP_LOAD, addr, {1'b0, 7'($urandom)});
                send_item(OP_LOAD, addr, {1'b1, 7'($urandom)});
            end
            else
                send_item(2'($urandom), 16'($urandom), 8'($urandom));
        end
    endtask

    // Power-up offsets, ignored items, and a count change before any load
    task automatic test_power_up();
        send_item(OP_READ,   16'h0000, 8'h00);
        send_item(OP_READ,   16'h1FFF, 8'hFF);
        send_item(OP_READ,   16'h8000, 8'h00);
        send_item(OP_WRITE,  16'hFFFF, 8'hFF);
        send_item(OP_LOAD,   16'h7FFF, 8'h01);
        send_item(OP_UNUSED, 16'hFFFF, 8'hFF);
        set_bank_counts(6'd5, 6'd3);
        send_item(OP_READ,   16'hC000, 8'h00);
    endtask

    // Region boundaries with writes that must not reach memory
    task automatic test_access_map();
        send_item(OP_WRITE, 16'h2000, 8'hFF);
        send_item(OP_READ,  16'h5FFF, 8'h00);
        send_item(OP_WRITE, 16'h6000, 8'h5A);
        send_item(OP_WRITE, 16'h7FFF, 8'hA5);
    endtask

    // Partial load, shifter reset, then control and program bank loads
    task automatic test_serial_loads();
        send_item(OP_LOAD, 16'h8000, 8'h01);
        send_item(OP_LOAD, 16'hE000, 8'h7F);
        send_item(OP_LOAD, 16'hFFFF, 8'h80);
        send_item(OP_READ, 16'hC000, 8'h00);
        load_register(16'h9FFF, 5'h1F);
        load_register(16'hFFFF, 5'h1F);
        send_item(OP_READ, 16'h8000, 8'h00);
    endtask

    // Several bank counts, extremes and out of range included, under random traffic
    task automatic test_bank_count_sweep();
        logic [COUNT_W-1:0] prg_counts [7] = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd8, 6'd3, 6'd17};
        logic [COUNT_W-1:0] chr_counts [7] = '{6'd32, 6'd1, 6'd63, 6'd0, 6'd2, 6'd5, 6'd31};
        int                 gap_profile   [7] = '{5, 0, 5, 0, 2, 5, 1};
        int                 stall_profile [7] = '{5, 0, 0, 5, 5, 1, 3};
        for (int p = 0; p < 7; p++)
        begin
            set_bank_counts(prg_counts[p], chr_counts[p]);
            src_gap_max   = gap_profile[p];
            snk_stall_max = stall_profile[p];
            random_traffic(175);
        end
    endtask

    // Accept results after random stalls and compare with the oldest translation
    initial
    begin
        int           stall;
        slbm_result_t got;
        slbm_result_t want;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, snk_stall_max);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            got.region          = m_tuser;
            got.physical_offset = m_tdata[18:0];
            got.is_write        = m_tdata[19];
            got.write_data      = m_tdata[27:20];
            got.mirroring       = m_tdata[29:28];
            if (pending_translations.size() == 0)
            begin
                $error("unexpected result item: region %0d", got.region);
                error_count++;
            end
            else
            begin
                want = pending_translations.pop_front();
                if (got.region !== want.region)
                begin
                    $error("region: expected %0d, actual %0d", want.region, got.region);
                    error_count++;
                end
                if (got.physical_offset !== want.physical_offset)
                begin
                    $error("physical_offset: expected 0x%05h, actual 0x%05h",
                           want.physical_offset, got.physical_offset);
                    error_count++;
                end
                if (got.is_write !== want.is_write)
                begin
                    $error("is_write: expected %0d, actual %0d", want.is_write, got.is_write);
                    error_count++;
                end
                if (got.write_data !== want.write_data)
                begin
                    $error("write_data: expected 0x%02h, actual 0x%02h",
                           want.write_data, got.write_data);
                    error_count++;
                end
                if (got.mirroring !== want.mirroring)
                begin
                    $error("mirroring: expected %0d, actual %0d", want.mirroring, got.mirroring);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_READ;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_PRG_COUNT;
        cfg_data  <= '0;
        load_power_up_offsets();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_up();
        test_access_map();
        test_serial_loads();
        test_bank_count_sweep();
        wait_idle();

        if (error_count == 0 && pending_translations.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/slbm_pkg.sv
src/slbm_front.sv
src/slbm_queue.sv
src/slbm_modulo.sv
src/slbm_back.sv
src/serial_loaded_bank_mapper.sv
sim/testbench.sv
